@@ design/fsu_pkg.sv @@
// Package: shared widths, commands, status codes and state types of the frame stack unit.
`default_nettype none
package fsu_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int MAX_LEVELS  = 16;

   localparam int AW = $clog2(STACK_DEPTH);   // stack word address
   localparam int CW = AW + 1;                // word count, base pointer
   localparam int LW = $clog2(MAX_LEVELS);    // display index

   localparam int MODE_W   = 4;
   localparam int WORD_W   = 32;
   localparam int LEVEL_W  = 4;
   localparam int OFF_W    = 11;
   localparam int FW_W     = 11;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 11;

   localparam int LINK_SLOTS        = 3;
   localparam int FRAME_LIMIT_RESET = 256;

   // Command queue entries; the front end pointers are one bit wide
   localparam int QUEUE_DEPTH = 2;

   // Input command codes
   localparam logic [MODE_W-1:0] MODE_PUSH    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_TOP     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_PUSHF   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_POPF    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_LOAD    = 4'd5;
   localparam logic [MODE_W-1:0] MODE_STORE   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_SETD    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_GETD    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd9;

   typedef enum logic [3:0] {
      OP_PUSH, OP_POP, OP_TOP, OP_PUSHF, OP_POPF,
      OP_LOAD, OP_STORE, OP_SETD, OP_GETD, OP_CLEAR, OP_NONE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_FOVER   = 3'd2,
      ST_CORRUPT = 3'd3,
      ST_BOUNDS  = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_READ, S_FILL, S_POPF, S_WALK, S_WALK_WAIT
   } state_type;

   // Classified command as held in the queue
   typedef struct packed {
      op_type                    op;
      logic signed [WORD_W-1:0]  value;
      logic [LEVEL_W-1:0]        level;
      logic signed [OFF_W-1:0]   offset;
      logic [FW_W-1:0]           frame_words;
      logic [WORD_W-1:0]         static_link;
      logic [WORD_W-1:0]         return_address;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage
`default_nettype wire

@@ design/fsu_req_if.sv @@
// Interface: command channel of the frame stack unit.
`default_nettype none
interface fsu_req_if import fsu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [WORD_W-1:0]  value;
   logic [LEVEL_W-1:0]        level;
   logic signed [OFF_W-1:0]   offset;
   logic [FW_W-1:0]           frame_words;
   logic signed [WORD_W-1:0]  static_link;
   logic signed [WORD_W-1:0]  return_address;

   modport source (output valid, mode, value, level, offset, frame_words,
                   static_link, return_address, input ready);
   modport sink (input valid, mode, value, level, offset, frame_words,
                 static_link, return_address, output ready);
endinterface
`default_nettype wire

@@ design/fsu_rsp_if.sv @@
// Interface: result channel of the frame stack unit.
`default_nettype none
interface fsu_rsp_if import fsu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  data;
   logic [STATUS_W-1:0]       status;
   logic signed [CW-1:0]      frame_base;
   logic [CW-1:0]             open_frames;
   logic                      stack_empty;

   modport source (output valid, data, status, frame_base, open_frames, stack_empty,
                   input ready);
   modport sink (input valid, data, status, frame_base, open_frames, stack_empty,
                 output ready);
endinterface
`default_nettype wire

@@ design/fsu_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/fsu_front.sv @@
// Front end: accepts command items, classifies them and queues them for the back end.
`default_nettype none
module fsu_front import fsu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   fsu_req_if.sink       req_ch,
   input  wire logic     deq,
   output queue_head_type head
);
   cmd_type    q_ff [QUEUE_DEPTH];
   cmd_type    q_in [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       enq;
   cmd_type    cls;

   // Classify: mode to operation, small frames raised to the link slots
   always_comb begin
      cls.value          = req_ch.value;
      cls.level          = req_ch.level;
      cls.offset         = req_ch.offset;
      cls.static_link    = req_ch.static_link;
      cls.return_address = req_ch.return_address;
      cls.frame_words    = (req_ch.frame_words < FW_W'(LINK_SLOTS)) ?
                           FW_W'(LINK_SLOTS) : req_ch.frame_words;
      case (req_ch.mode)
         MODE_PUSH:  cls.op = OP_PUSH;
         MODE_POP:   cls.op = OP_POP;
         MODE_TOP:   cls.op = OP_TOP;
         MODE_PUSHF: cls.op = OP_PUSHF;
         MODE_POPF:  cls.op = OP_POPF;
         MODE_LOAD:  cls.op = OP_LOAD;
         MODE_STORE: cls.op = OP_STORE;
         MODE_SETD:  cls.op = OP_SETD;
         MODE_GETD:  cls.op = OP_GETD;
         MODE_CLEAR: cls.op = OP_CLEAR;
         default:    cls.op = OP_NONE;
      endcase
   end

   assign req_ch.ready = (count_ff != 2'(QUEUE_DEPTH));
   assign enq          = req_ch.valid && req_ch.ready;
   assign head.valid   = (count_ff != 2'd0);
   assign head.cmd     = q_ff[rd_ptr_ff];

   // Queue pointers and storage
   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         q_in[wr_ptr_ff] = cls;
         wr_ptr_in       = ~wr_ptr_ff;
      end
      if (deq) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (enq && !deq) begin
         count_in = count_ff + 2'd1;
      end else if (!enq && deq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      q_ff <= q_in;
   end
endmodule
`default_nettype wire

@@ design/fsu_back.sv @@
// Back end: executes queued commands on the stack memory and registers the result item.
`default_nettype none
module fsu_back import fsu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [LIMIT_W-1:0] frame_limit,
   input  wire queue_head_type     head,
   output logic                    deq,
   fsu_rsp_if.source               rsp_ch
);
   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [CW-1:0]             wc_ff, wc_in;
   logic signed [CW-1:0]      bp_ff, bp_in;
   logic [CW-1:0]             ft_ff, ft_in;
   logic [LW:0]               used_ff, used_in;
   logic [WORD_W-1:0]         disp_ff [MAX_LEVELS];
   logic [WORD_W-1:0]         disp_in [MAX_LEVELS];
   logic signed [LW+1:0]      cur_ff, cur_in;
   logic signed [WORD_W-1:0]  cursor_ff, cursor_in;
   logic [CW-1:0]             fill_ff, fill_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [CW-1:0]      rsp_base_ff, rsp_base_in;
   logic [CW-1:0]             rsp_open_ff, rsp_open_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [WORD_W-1:0]         ram_wdata, ram_rdata;

   logic                      finish;
   logic [WORD_W-1:0]         res_data;
   status_type                res_status;

   logic                      out_free;
   logic signed [WORD_W-1:0]  bp32, wc32, dyn;
   logic signed [CW:0]        bp_p1;
   logic [CW:0]               frame_end;
   logic signed [WORD_W:0]    abs_addr;
   logic                      full_word, frame_full, frame_over, popf_bad, dyn_bad;
   logic                      walk_more, cursor_bad, protect, abs_bad, last_fill;

   fsu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared conditions
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign deq        = (state_ff == S_IDLE) && head.valid && out_free;
   assign bp32       = WORD_W'(bp_ff);
   assign wc32       = $signed({{(WORD_W-CW){1'b0}}, wc_ff});
   assign dyn        = $signed(ram_rdata);
   assign bp_p1      = $signed({bp_ff[CW-1], bp_ff}) + $signed((CW+1)'(1));
   assign frame_end  = {1'b0, wc_ff} + (CW+1)'(cmd_ff.frame_words);
   assign full_word  = wc_ff >= CW'(STACK_DEPTH);
   assign frame_over = ft_ff >= CW'(frame_limit);
   assign frame_full = frame_end > (CW+1)'(STACK_DEPTH);
   assign popf_bad   = (ft_ff == '0) || (bp_ff < 0) || (bp_p1 >= $signed({1'b0, wc_ff}));
   assign dyn_bad    = (dyn < -32'sd1) || (dyn >= bp32);
   assign walk_more  = cur_ff > $signed((LW+2)'(cmd_ff.level));
   assign cursor_bad = (cursor_ff < 0) || (cursor_ff >= wc32);
   assign abs_addr   = $signed({cursor_ff[WORD_W-1], cursor_ff}) +
                       $signed((WORD_W+1)'(cmd_ff.offset));
   assign abs_bad    = (abs_addr < 0) || (abs_addr >= $signed({1'b0, wc32}));
   assign protect    = (cursor_ff == bp32) && (cmd_ff.offset >= 0) &&
                       (cmd_ff.offset <= $signed(OFF_W'(2)));
   assign last_fill  = fill_ff == (CW'(cmd_ff.frame_words) - CW'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (deq) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (cmd_ff.op)
               OP_POP, OP_TOP: state_in = (wc_ff != '0) ? S_READ : S_IDLE;
               OP_PUSHF: state_in = (frame_over || frame_full) ? S_IDLE : S_FILL;
               OP_POPF:  state_in = popf_bad ? S_IDLE : S_POPF;
               OP_LOAD, OP_STORE: state_in = S_WALK;
               default:  state_in = S_IDLE;
            endcase
         end
         S_FILL: begin
            if (last_fill) state_in = S_IDLE;
         end
         S_WALK: begin
            if (walk_more) begin
               state_in = cursor_bad ? S_IDLE : S_WALK_WAIT;
            end else if (cmd_ff.op == OP_LOAD && !abs_bad) begin
               state_in = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK_WAIT: state_in = S_WALK;
         S_READ:      state_in = S_IDLE;
         S_POPF:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and result
   always_comb begin
      cmd_in     = cmd_ff;
      wc_in      = wc_ff;
      bp_in      = bp_ff;
      ft_in      = ft_ff;
      used_in    = used_ff;
      disp_in    = disp_ff;
      cur_in     = cur_ff;
      cursor_in  = cursor_ff;
      fill_in    = fill_ff;
      ram_we     = 1'b0;
      ram_waddr  = wc_ff[AW-1:0];
      ram_wdata  = cmd_ff.value;
      ram_raddr  = '0;
      finish     = 1'b0;
      res_data   = '0;
      res_status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (deq) cmd_in = head.cmd;
         end
         S_DISPATCH: begin
            case (cmd_ff.op)
               OP_PUSH: begin
                  finish = 1'b1;
                  if (full_word) begin
                     res_status = ST_FULL;
                  end else begin
                     ram_we = 1'b1;
                     wc_in  = wc_ff + CW'(1);
                  end
               end
               OP_POP, OP_TOP: begin
                  ram_raddr = AW'(wc_ff - CW'(1));
                  if (wc_ff == '0) begin
                     finish     = 1'b1;
                     res_status = ST_UNDER;
                  end
               end
               OP_PUSHF: begin
                  if (frame_over) begin
                     finish     = 1'b1;
                     res_status = ST_FOVER;
                  end else if (frame_full) begin
                     finish     = 1'b1;
                     res_status = ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_wdata = cmd_ff.static_link;
                     fill_in   = CW'(1);
                  end
               end
               OP_POPF: begin
                  ram_raddr = bp_p1[AW-1:0];
                  if (popf_bad) begin
                     finish     = 1'b1;
                     res_status = ST_CORRUPT;
                  end
               end
               OP_LOAD, OP_STORE: begin
                  cur_in    = $signed({1'b0, used_ff}) - $signed((LW+2)'(1));
                  cursor_in = bp32;
               end
               OP_SETD: begin
                  finish = 1'b1;
                  if ((LW+1)'(cmd_ff.level) >= (LW+1)'(MAX_LEVELS)) begin
                     res_status = ST_BOUNDS;
                  end else begin
                     // zero any unset levels below the one written
                     for (int j = 0; j < MAX_LEVELS; j++) begin
                        if ((LW+1)'(j) >= used_ff && (LW+1)'(j) < (LW+1)'(cmd_ff.level))
                           disp_in[j] = '0;
                     end
                     disp_in[cmd_ff.level[LW-1:0]] = cmd_ff.value;
                     if ((LW+1)'(cmd_ff.level) >= used_ff)
                        used_in = (LW+1)'(cmd_ff.level) + (LW+1)'(1);
                  end
               end
               OP_GETD: begin
                  finish = 1'b1;
                  if ((LW+1)'(cmd_ff.level) < used_ff)
                     res_data = disp_ff[cmd_ff.level[LW-1:0]];
               end
               OP_CLEAR: begin
                  finish  = 1'b1;
                  wc_in   = '0;
                  used_in = '0;
                  bp_in   = -CW'(1);
                  ft_in   = '0;
               end
               default: finish = 1'b1;
            endcase
         end
         S_FILL: begin
            // dynamic link, return address, then zero words
            ram_we    = 1'b1;
            ram_waddr = AW'(wc_ff + fill_ff);
            if (fill_ff == CW'(1)) ram_wdata = bp32;
            else if (fill_ff == CW'(2)) ram_wdata = cmd_ff.return_address;
            else ram_wdata = '0;
            fill_in = fill_ff + CW'(1);
            if (last_fill) begin
               finish = 1'b1;
               wc_in  = frame_end[CW-1:0];
               bp_in  = $signed(wc_ff);
               ft_in  = ft_ff + CW'(1);
            end
         end
         S_WALK: begin
            if (walk_more) begin
               ram_raddr = cursor_ff[AW-1:0];
               cur_in    = cur_ff - $signed((LW+2)'(1));
               if (cursor_bad) begin
                  finish     = 1'b1;
                  res_status = ST_CORRUPT;
               end
            end else begin
               ram_raddr = abs_addr[AW-1:0];
               ram_waddr = abs_addr[AW-1:0];
               if (cmd_ff.op == OP_STORE && protect) begin
                  finish     = 1'b1;
                  res_status = ST_CORRUPT;
               end else if (abs_bad) begin
                  finish     = 1'b1;
                  res_status = ST_BOUNDS;
               end else if (cmd_ff.op == OP_STORE) begin
                  finish = 1'b1;
                  ram_we = 1'b1;
               end
            end
         end
         S_WALK_WAIT: cursor_in = dyn;
         S_READ: begin
            finish   = 1'b1;
            res_data = ram_rdata;
            if (cmd_ff.op == OP_POP) wc_in = wc_ff - CW'(1);
         end
         S_POPF: begin
            finish = 1'b1;
            if (dyn_bad) begin
               res_status = ST_CORRUPT;
            end else begin
               wc_in = bp_ff;
               bp_in = CW'(dyn);
               ft_in = ft_ff - CW'(1);
            end
         end
         default: ;
      endcase

      // result register; only loaded when the slot is free
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data;
         rsp_status_in = res_status;
         rsp_base_in   = bp_in;
         rsp_open_in   = ft_in;
         rsp_empty_in  = (wc_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wc_ff        <= '0;
         bp_ff        <= -CW'(1);
         ft_ff        <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wc_ff        <= wc_in;
         bp_ff        <= bp_in;
         ft_ff        <= ft_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      disp_ff       <= disp_in;
      cur_ff        <= cur_in;
      cursor_ff     <= cursor_in;
      fill_ff       <= fill_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data        = rsp_data_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.frame_base  = rsp_base_ff;
   assign rsp_ch.open_frames = rsp_open_ff;
   assign rsp_ch.stack_empty = rsp_empty_ff;
endmodule
`default_nettype wire

@@ design/frame_stack_unit_core.sv @@
// Top level: frame stack unit with command queue, executor and frame limit register.
// Each command item yields one result item. A two-entry queue takes items while the
// executor works; the executor starts one item at a time once the result register is
// free. In the executor, push frame makes one stack memory write per word (minimum
// 3 words); store and load walk down the static chain with one read of the
// single-read-port stack memory per link, and load makes one more read for the
// word. The frame limit register is written through csr_we/csr_wdata; the user
// must write it only while the unit is idle, which the block itself does not
// enforce. It resets to 256.
`default_nettype none
module frame_stack_unit_core import fsu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   fsu_req_if.sink                 req_ch,
   fsu_rsp_if.source               rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);
   logic [LIMIT_W-1:0] frame_limit_ff, frame_limit_in;
   queue_head_type     head;
   logic               deq;

   // Frame limit register
   assign frame_limit_in = csr_we ? csr_wdata : frame_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= LIMIT_W'(FRAME_LIMIT_RESET);
      end else begin
         frame_limit_ff <= frame_limit_in;
      end
   end

   fsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .deq    (deq),
      .head   (head)
   );

   fsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_limit (frame_limit_ff),
      .head        (head),
      .deq         (deq),
      .rsp_ch      (rsp_ch)
   );

   // An accepted item is queued on the next cycle
   a_enq_visible: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> head.valid)
      else $error("accepted item missing from queue");

   // The executor never starts while a result is still held
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      deq |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("executor started with result pending");

   // Dequeue only from a non-empty queue
   a_deq_valid: assert property (@(posedge clock) disable iff (reset)
      deq |-> head.valid)
      else $error("dequeue from empty queue");
endmodule
`default_nettype wire
